[hdl/rrsq_pkg.sv]
// ----------------------------------------------------------------------------
// rrsq_pkg
// Shared types and constants for the RR interval symbolic quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrsq_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SYMBOL_W = 4;

    // Default delay line depths
    localparam int RAW_DELAY_DEF     = 8;
    localparam int LOWPASS_DELAY_DEF = 4;

    // Number of decision thresholds (ten symbols)
    localparam int NUM_THRESH = 9;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SYMBOL_W-1:0] symbol_t;

    // Payload of one input transfer
    typedef struct packed {
        sample_t rr_sample;
        sample_t lowpass_sample;
        sample_t highpass_sample;
    } in_item_t;

    // Payload of one output transfer
    typedef struct packed {
        symbol_t symbol;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/rrsq_stream_if.sv]
// ----------------------------------------------------------------------------
// rrsq_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrsq_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[hdl/rrsq_delay_cell.sv]
// ----------------------------------------------------------------------------
// rrsq_delay_cell
// One stage of a sample delay line; passes its sample on at each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrsq_delay_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire rrsq_pkg::sample_t sample_prev,
    output rrsq_pkg::sample_t      sample_hold
);
    import rrsq_pkg::*;

    sample_t sample_reg;

    // Line starts out all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= sample_prev;
        end
    end

    assign sample_hold = sample_reg;

endmodule

`default_nettype wire

[hdl/rrsq_quantizer.sv]
// ----------------------------------------------------------------------------
// rrsq_quantizer
// Maps the delayed raw minus low-pass difference to a symbol 0..9.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrsq_quantizer (
    input  wire rrsq_pkg::sample_t raw_delayed,
    input  wire rrsq_pkg::sample_t low_delayed,
    input  wire rrsq_pkg::sample_t highpass,
    output rrsq_pkg::symbol_t      symbol
);
    import rrsq_pkg::*;

    sample_t                 diff_w;
    logic signed [SAMPLE_W:0] diff_s;
    logic signed [SAMPLE_W:0] t1, t2, t3, t4, t5;
    logic [NUM_THRESH-1:0]   at_or_above;

    // Difference wraps to 16 bits, then read as signed
    assign diff_w = raw_delayed - low_delayed;
    assign diff_s = {diff_w[SAMPLE_W-1], diff_w};

    // Thresholds by shifts; all stay below 2^15
    assign t1 = {5'b0, highpass[SAMPLE_W-1:4]};
    assign t2 = {4'b0, highpass[SAMPLE_W-1:3]};
    assign t4 = {3'b0, highpass[SAMPLE_W-1:2]};
    assign t3 = t1 + t2;
    assign t5 = t4 + t1;

    // Thresholds are non-decreasing (-t4 <= -t3 <= ... <= t4 <= t5), so the
    // first failing test in order equals the count of thresholds passed.
    always_comb
    begin
        at_or_above[0] = (diff_s >= -t4);
        at_or_above[1] = (diff_s >= -t3);
        at_or_above[2] = (diff_s >= -t2);
        at_or_above[3] = (diff_s >= -t1);
        at_or_above[4] = (diff_s >= t1);
        at_or_above[5] = (diff_s >= t2);
        at_or_above[6] = (diff_s >= t3);
        at_or_above[7] = (diff_s >= t4);
        at_or_above[8] = (diff_s >= t5);
    end

    assign symbol = symbol_t'($countones(at_or_above));

endmodule

`default_nettype wire

[hdl/rr_symbolic_quantizer.sv]
// ----------------------------------------------------------------------------
// rr_symbolic_quantizer
// RR interval symbolic coder: delayed raw minus delayed low-pass, quantized
// against high-pass scaled thresholds into ten symbols.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                         per transfer
//  items     in    rr_sample, lowpass_sample, highpass_sample      one beat
//  symbols   out   symbol (0..9)                                   one symbol
//
//  One item per cycle sustained while the output is not stalled; each symbol
//  appears the cycle after its item is taken, from a single output register.
//  Both delay lines are chains of cells that shift once per input transfer.
//  Reset clears the delay lines to zero and empties the output register.
//  A stalled output holds its symbol; items are still taken in the cycle the
//  waiting symbol leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rr_symbolic_quantizer #(
    parameter int RAW_DELAY     = rrsq_pkg::RAW_DELAY_DEF,
    parameter int LOWPASS_DELAY = rrsq_pkg::LOWPASS_DELAY_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rrsq_stream_if.sink   items,
    rrsq_stream_if.source symbols
);
    import rrsq_pkg::*;

    logic    in_fire;
    logic    out_valid_reg;
    logic    out_valid_next;
    symbol_t symbol_reg;
    symbol_t symbol_next;
    sample_t raw_tap [0:RAW_DELAY];
    sample_t low_tap [0:LOWPASS_DELAY];

    // Take a new item whenever the output register is free or draining
    assign items.ready = !out_valid_reg || symbols.ready;
    assign in_fire     = items.valid && items.ready;

    // Raw delay line
    assign raw_tap[0] = items.data.rr_sample;
    for (genvar i = 0; i < RAW_DELAY; i++)
    begin : g_raw
        rrsq_delay_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (in_fire),
            .sample_prev (raw_tap[i]),
            .sample_hold (raw_tap[i+1])
        );
    end

    // Low-pass delay line
    assign low_tap[0] = items.data.lowpass_sample;
    for (genvar i = 0; i < LOWPASS_DELAY; i++)
    begin : g_low
        rrsq_delay_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (in_fire),
            .sample_prev (low_tap[i]),
            .sample_hold (low_tap[i+1])
        );
    end

    // Symbol from the samples leaving each line
    rrsq_quantizer u_quantizer (
        .raw_delayed (raw_tap[RAW_DELAY]),
        .low_delayed (low_tap[LOWPASS_DELAY]),
        .highpass    (items.data.highpass_sample),
        .symbol      (symbol_next)
    );

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (symbols.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            symbol_reg <= symbol_next;
        end
    end

    assign symbols.valid       = out_valid_reg;
    assign symbols.data.symbol = symbol_reg;

endmodule

`default_nettype wire

[hdl/rrsq_checker.sv]
// ----------------------------------------------------------------------------
// rrsq_checker
// Port-level checks for the RR interval symbolic quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrsq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire rrsq_pkg::symbol_t symbol
);
    import rrsq_pkg::*;

    localparam symbol_t SYMBOL_MAX = symbol_t'(NUM_THRESH);

    // Only ten symbols exist
    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol <= SYMBOL_MAX))
        else $error("symbol out of range");

    // Every taken item shows a symbol in the next cycle
    a_item_to_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("taken item gave no symbol");

    // Single output slot: no intake while a symbol is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item taken while output stalled");

    // A symbol appears only after an item was taken
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
        else $error("symbol without item");

    // Stalled symbol holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(symbol)))
        else $error("stalled symbol changed");

endmodule

bind rr_symbolic_quantizer rrsq_checker u_rrsq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (symbols.valid),
    .out_ready (symbols.ready),
    .symbol    (symbols.data.symbol)
);

`default_nettype wire
